// ----- src/srsc_pkg.sv -----
// Shared types and codes for the shadow return stack checker.
`timescale 1ns / 1ps
`default_nettype none

package srsc_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_MISMATCH = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;
	localparam status_t ST_OVERFLOW = 2'd3;

	localparam logic CMD_CALL   = 1'b0;
	localparam logic CMD_RETURN = 1'b1;

	// Control carried alongside a word from the front stage to the check stage.
	typedef struct packed {
		logic valid;
		logic is_return;
		logic empty;
		logic overflow;
	} srsc_ctl_t;

endpackage

`default_nettype wire

// ----- src/srsc_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module srsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/srsc_front.sv -----
// Front stage: stack pointer and count, RAM access and the stage-one register.
`timescale 1ns / 1ps
`default_nettype none

module srsc_front import srsc_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int ADDR_WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     event_valid,
	output logic                          event_ready,
	input  wire logic                     command,
	input  wire logic [ADDR_WIDTH-1:0]    call_address,
	input  wire logic [3:0]               call_length,
	input  wire logic [ADDR_WIDTH-1:0]    stack_return_address,
	input  wire logic                     advance,
	output logic                          ram_we,
	output logic [$clog2(DEPTH)-1:0]      ram_waddr,
	output logic [ADDR_WIDTH-1:0]         ram_wdata,
	output logic                          ram_re,
	output logic [$clog2(DEPTH)-1:0]      ram_raddr,
	output srsc_ctl_t                     ctl_s1,
	output logic [ADDR_WIDTH-1:0]         addr_s1
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [PTR_W-1:0] top_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] top_next;
	logic [PTR_W-1:0] top_prev;
	logic             accept;
	logic             is_full;
	logic             is_empty;
	logic [ADDR_WIDTH-1:0] push_value;

	assign event_ready = !ctl_s1.valid || advance;
	assign accept      = event_valid && event_ready;
	assign is_full     = (count_q == CNT_FULL);
	assign is_empty    = (count_q == '0);
	assign top_next    = (top_q == PTR_LAST) ? '0 : top_q + PTR_W'(1);
	assign top_prev    = (top_q == '0) ? PTR_LAST : top_q - PTR_W'(1);
	assign push_value  = call_address + {{(ADDR_WIDTH-4){1'b0}}, call_length};

	// A call writes the slot at the pointer, a return reads the slot below it.
	assign ram_we    = accept && (command == CMD_CALL);
	assign ram_waddr = top_q;
	assign ram_wdata = push_value;
	assign ram_re    = accept && (command == CMD_RETURN) && !is_empty;
	assign ram_raddr = top_prev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (command == CMD_CALL) begin
				top_q <= top_next;
				if (!is_full) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (!is_empty) begin
				top_q   <= top_prev;
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			if (event_ready) begin
				ctl_s1.valid <= event_valid;
			end
			if (accept) begin
				ctl_s1.is_return <= (command == CMD_RETURN);
				ctl_s1.empty     <= is_empty;
				ctl_s1.overflow  <= is_full;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= (command == CMD_CALL) ? push_value : stack_return_address;
		end
	end

endmodule

`default_nettype wire

// ----- src/srsc_check.sv -----
// Check stage: compares against the read entry and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module srsc_check import srsc_pkg::*; #(
	parameter int ADDR_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire srsc_ctl_t             ctl_s1,
	input  wire logic [ADDR_WIDTH-1:0] addr_s1,
	input  wire logic [ADDR_WIDTH-1:0] ram_rdata,
	output logic                       advance,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic [1:0]                 status,
	output logic [ADDR_WIDTH-1:0]      expected_address
);

	status_t               status_d;
	logic [ADDR_WIDTH-1:0] expected_d;

	assign advance = ctl_s1.valid && (!result_valid || result_ready);

	always_comb begin
		if (!ctl_s1.is_return) begin
			expected_d = addr_s1;
			status_d   = ctl_s1.overflow ? ST_OVERFLOW : ST_OK;
		end else if (ctl_s1.empty) begin
			expected_d = '0;
			status_d   = ST_EMPTY;
		end else begin
			expected_d = ram_rdata;
			status_d   = (ram_rdata != addr_s1) ? ST_MISMATCH : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!result_valid || result_ready) begin
			result_valid <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status           <= status_d;
			expected_address <= expected_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/shadow_return_stack_checker_core.sv -----
// Top level of the shadow return stack checker.
// Throughput: one event word per cycle unless result_ready stalls the output, set
// by the single RAM access per event (one write port, one registered read port)
// and the two-register pipeline (stage-one register, then result register).
// Reset clears the stack pointer, the entry count and both valid flags at once.
// The entry RAM is not cleared; the count keeps unwritten entries from being read.
`timescale 1ns / 1ps
`default_nettype none

module shadow_return_stack_checker_core import srsc_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int ADDR_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  event_valid,
	output logic                       event_ready,
	input  wire logic                  command,
	input  wire logic [ADDR_WIDTH-1:0] call_address,
	input  wire logic [3:0]            call_length,
	input  wire logic [ADDR_WIDTH-1:0] stack_return_address,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output logic [1:0]                 status,
	output logic [ADDR_WIDTH-1:0]      expected_address
);

	localparam int PTR_W = $clog2(DEPTH);

	logic                  ram_we;
	logic [PTR_W-1:0]      ram_waddr;
	logic [ADDR_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [PTR_W-1:0]      ram_raddr;
	logic [ADDR_WIDTH-1:0] ram_rdata;
	srsc_ctl_t             ctl_s1;
	logic [ADDR_WIDTH-1:0] addr_s1;
	logic                  advance;

	srsc_front #(
		.DEPTH      (DEPTH),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.event_valid          (event_valid),
		.event_ready          (event_ready),
		.command              (command),
		.call_address         (call_address),
		.call_length          (call_length),
		.stack_return_address (stack_return_address),
		.advance              (advance),
		.ram_we               (ram_we),
		.ram_waddr            (ram_waddr),
		.ram_wdata            (ram_wdata),
		.ram_re               (ram_re),
		.ram_raddr            (ram_raddr),
		.ctl_s1               (ctl_s1),
		.addr_s1              (addr_s1)
	);

	srsc_ram #(
		.WIDTH (ADDR_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srsc_check #(
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl_s1           (ctl_s1),
		.addr_s1          (addr_s1),
		.ram_rdata        (ram_rdata),
		.advance          (advance),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.status           (status),
		.expected_address (expected_address)
	);

endmodule

`default_nettype wire

// ----- src/srsc_checker.sv -----
// Port-level assertions for the shadow return stack checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module srsc_checker import srsc_pkg::*; #(
	parameter int ADDR_WIDTH = 64
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  event_valid,
	input wire logic                  event_ready,
	input wire logic                  result_valid,
	input wire logic                  result_ready,
	input wire logic [1:0]            status,
	input wire logic [ADDR_WIDTH-1:0] expected_address
);

	// A stalled result word keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status)
			&& $stable(expected_address))
		else $error("result word changed while stalled");

	// An unchecked return on an empty stack reports a zero address.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_EMPTY) |-> (expected_address == '0))
		else $error("empty-stack return with nonzero address");

	// An accepted word reaches the result register when result_ready does not stall it.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && event_ready) ##1 result_ready |=> result_valid)
		else $error("result word missing after two cycles");

	// With no result waiting, the pipeline always has room for a new word.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> event_ready)
		else $error("event channel blocked with output empty");

endmodule

bind shadow_return_stack_checker_core srsc_checker #(
	.ADDR_WIDTH (ADDR_WIDTH)
) u_srsc_checker (.*);

`default_nettype wire
